>>> design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/bmprle_pkg.sv
`timescale 1ns / 1ps
package bmprle_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int COORD_BITS    = 16;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int POS_W         = COORD_BITS + 1;
  localparam logic [8:0] PAL_DEPTH_C = 9'(PALETTE_DEPTH);

  localparam int CFG_AW = 4;

  // Register indexes (byte address bits [3:2]).
  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_NIBBLE  = 2'd2;
  localparam logic [1:0] REG_ENTRIES = 2'd3;

  // Input operations.
  localparam logic [1:0] OP_PAL   = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_EOS   = 2'd2;
  localparam logic [1:0] OP_START = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_SPAN = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  localparam logic [7:0] NIB_MASK = 8'h0F;

  typedef struct packed {
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        nibble_mode;
    logic [8:0]  palette_entries;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  len;
    logic        odd_used;
  } res_t;

endpackage

>>> design/bmprle_ifs.sv
`timescale 1ns / 1ps
interface bmprle_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  palette_slot;
  logic [31:0] palette_argb;
  logic [7:0]  data_byte;

  modport source (output valid, operation, palette_slot, palette_argb, data_byte,
                  input ready);
  modport sink (input valid, operation, palette_slot, palette_argb, data_byte,
                output ready);
endinterface

interface bmprle_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] span_x;
  logic [15:0] span_y;
  logic [7:0]  span_length;
  logic [31:0] even_colour;
  logic [31:0] odd_colour;

  modport source (output valid, kind, span_x, span_y, span_length, even_colour,
                  odd_colour, input ready);
  modport sink (input valid, kind, span_x, span_y, span_length, even_colour,
                odd_colour, output ready);
endinterface

>>> design/bmp_rle_pixel_decoder.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake        Beat contents
// in_ch     in         valid / ready    operation, palette_slot, palette_argb, data_byte
// out_ch    out        valid / ready    kind, span_x, span_y, span_length, colours
// APB       in         psel / penable   width, height, nibble mode, palette entries
//
// One input beat per cycle while input ready is high; a result is registered in the read
// stage, beside the palette RAM read, and then in the output register.
// Reset is synchronous: it clears the parser, the pipeline and the registers;
// the palette RAM keeps its contents and is not swept.
// A stalled output holds its beat; one more result waits in the read stage,
// and input ready drops only when both are full.
module bmp_rle_pixel_decoder
  import bmprle_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  bmprle_in_if.sink         in_ch,
  bmprle_out_if.source      out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t              cfg;
  res_t              res;
  logic              accept;
  logic              in_ready;
  logic              pal_we;
  logic [PAL_AW-1:0] pal_waddr;
  logic [31:0]       pal_wdata;
  logic              pal_re;
  logic [PAL_AW-1:0] even_addr, odd_addr;
  logic [31:0]       even_rdata, odd_rdata;

  assign accept      = in_ch.valid & in_ready;
  assign in_ch.ready = in_ready;

  bmprle_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bmprle_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .accept       (accept),
    .operation    (in_ch.operation),
    .palette_slot (in_ch.palette_slot),
    .palette_argb (in_ch.palette_argb),
    .data_byte    (in_ch.data_byte),
    .pal_we       (pal_we),
    .pal_waddr    (pal_waddr),
    .pal_wdata    (pal_wdata),
    .pal_re       (pal_re),
    .even_addr    (even_addr),
    .odd_addr     (odd_addr),
    .res          (res)
  );

  // Two copies of the palette give the two colour reads of a span in the same cycle.
  bmprle_ram #(.WIDTH(32), .DEPTH(PALETTE_DEPTH)) u_pal_even (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .re    (pal_re),
    .raddr (even_addr),
    .rdata (even_rdata)
  );

  bmprle_ram #(.WIDTH(32), .DEPTH(PALETTE_DEPTH)) u_pal_odd (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .re    (pal_re),
    .raddr (odd_addr),
    .rdata (odd_rdata)
  );

  bmprle_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .res        (res),
    .even_rdata (even_rdata),
    .odd_rdata  (odd_rdata),
    .in_ready   (in_ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_kind   (out_ch.kind),
    .out_x      (out_ch.span_x),
    .out_y      (out_ch.span_y),
    .out_len    (out_ch.span_length),
    .out_even   (out_ch.even_colour),
    .out_odd    (out_ch.odd_colour)
  );

endmodule

>>> design/bmprle_ram.sv
`timescale 1ns / 1ps
module bmprle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/bmprle_cfg.sv
`timescale 1ns / 1ps
module bmprle_cfg
  import bmprle_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t cfg_r, cfg_nxt;
  logic wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_WIDTH:   cfg_nxt.image_width     = pwdata[15:0];
        REG_HEIGHT:  cfg_nxt.image_height    = pwdata[15:0];
        REG_NIBBLE:  cfg_nxt.nibble_mode     = pwdata[0];
        REG_ENTRIES: cfg_nxt.palette_entries = pwdata[8:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:   prdata = {16'd0, cfg_r.image_width};
      REG_HEIGHT:  prdata = {16'd0, cfg_r.image_height};
      REG_NIBBLE:  prdata = {31'd0, cfg_r.nibble_mode};
      REG_ENTRIES: prdata = {23'd0, cfg_r.palette_entries};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width     <= 16'd1;
      cfg_r.image_height    <= 16'd1;
      cfg_r.nibble_mode     <= 1'b0;
      cfg_r.palette_entries <= 9'd256;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/bmprle_parser.sv
`timescale 1ns / 1ps
module bmprle_parser
  import bmprle_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              accept,
  input  logic [1:0]        operation,
  input  logic [7:0]        palette_slot,
  input  logic [31:0]       palette_argb,
  input  logic [7:0]        data_byte,
  output logic              pal_we,
  output logic [PAL_AW-1:0] pal_waddr,
  output logic [31:0]       pal_wdata,
  output logic              pal_re,
  output logic [PAL_AW-1:0] even_addr,
  output logic [PAL_AW-1:0] odd_addr,
  output res_t              res
);

  localparam logic [2:0] PH_COUNT = 3'd0;
  localparam logic [2:0] PH_CMD   = 3'd1;
  localparam logic [2:0] PH_DX    = 3'd2;
  localparam logic [2:0] PH_DY    = 3'd3;
  localparam logic [2:0] PH_LIT   = 3'd4;
  localparam logic [2:0] PH_PAD   = 3'd5;

  logic [2:0]       phase_r, phase_nxt;
  logic [7:0]       run_count_r, run_count_nxt;
  logic [POS_W-1:0] column_r, column_nxt;
  logic [POS_W-1:0] line_r, line_nxt;
  logic [7:0]       lit_pixels_r, lit_pixels_nxt;
  logic [7:0]       lit_left_r, lit_left_nxt;
  logic [7:0]       lit_index_r, lit_index_nxt;
  logic             pad_r, pad_nxt;
  logic [7:0]       dx_r, dx_nxt;
  logic             ended_r, ended_nxt;

  logic [COORD_BITS-1:0] w, h;
  logic                  sp_do;
  logic [7:0]            sp_len, sp_ei, sp_oi;
  logic                  fin;
  logic [1:0]            fin_kind;
  logic                  sp_ok;
  logic [POS_W:0]        sp_end;
  logic [POS_W-1:0]      y_full;
  logic [8:0]            lit_bytes;

  assign w = COORD_BITS'(cfg.image_width);
  assign h = COORD_BITS'(cfg.image_height);

  assign sp_end = {1'b0, column_r} + (POS_W + 1)'(sp_len);
  assign y_full = POS_W'(h) - POS_W'(1) - line_r;
  assign sp_ok  = (line_r < POS_W'(h)) && (sp_end <= (POS_W + 1)'(w)) &&
                  ({1'b0, sp_ei} < cfg.palette_entries) && ({1'b0, sp_ei} < PAL_DEPTH_C) &&
                  ((sp_len < 8'd2) ||
                   (({1'b0, sp_oi} < cfg.palette_entries) && ({1'b0, sp_oi} < PAL_DEPTH_C)));
  assign lit_bytes = cfg.nibble_mode ? ({1'b0, data_byte} + 9'd1) >> 1 : {1'b0, data_byte};

  always_comb begin
    phase_nxt      = phase_r;
    run_count_nxt  = run_count_r;
    column_nxt     = column_r;
    line_nxt       = line_r;
    lit_pixels_nxt = lit_pixels_r;
    lit_left_nxt   = lit_left_r;
    lit_index_nxt  = lit_index_r;
    pad_nxt        = pad_r;
    dx_nxt         = dx_r;
    ended_nxt      = ended_r;
    sp_do          = 1'b0;
    sp_len         = 8'd0;
    sp_ei          = 8'd0;
    sp_oi          = 8'd0;
    fin            = 1'b0;
    fin_kind       = KIND_FAIL;
    pal_we         = 1'b0;

    if (accept) begin
      case (operation)
        OP_PAL: begin
          pal_we = ({1'b0, palette_slot} < PAL_DEPTH_C);
        end
        OP_START: begin
          phase_nxt      = PH_COUNT;
          run_count_nxt  = 8'd0;
          column_nxt     = '0;
          line_nxt       = '0;
          lit_pixels_nxt = 8'd0;
          lit_left_nxt   = 8'd0;
          lit_index_nxt  = 8'd0;
          pad_nxt        = 1'b0;
          dx_nxt         = 8'd0;
          ended_nxt      = 1'b0;
        end
        OP_EOS: begin
          fin = !ended_r;
        end
        default: begin
          if (!ended_r) begin
            unique case (phase_r)
              PH_COUNT: begin
                run_count_nxt = data_byte;
                phase_nxt     = PH_CMD;
              end
              PH_CMD: begin
                phase_nxt = PH_COUNT;
                if (run_count_r != 8'd0) begin
                  sp_do  = 1'b1;
                  sp_len = run_count_r;
                  sp_ei  = cfg.nibble_mode ? data_byte >> 4 : data_byte;
                  sp_oi  = cfg.nibble_mode ? data_byte & NIB_MASK : data_byte;
                end else if (data_byte == 8'd0) begin
                  // End of line.
                  column_nxt = '0;
                  line_nxt   = line_r + POS_W'(1);
                  fin        = (line_nxt > POS_W'(h));
                end else if (data_byte == 8'd1) begin
                  fin      = 1'b1;
                  fin_kind = (line_r < POS_W'(h)) ? KIND_DONE : KIND_FAIL;
                end else if (data_byte == 8'd2) begin
                  phase_nxt = PH_DX;
                end else begin
                  lit_pixels_nxt = data_byte;
                  lit_left_nxt   = lit_bytes[7:0];
                  lit_index_nxt  = 8'd0;
                  pad_nxt        = lit_bytes[0];
                  phase_nxt      = PH_LIT;
                end
              end
              PH_DX: begin
                dx_nxt    = data_byte;
                phase_nxt = PH_DY;
              end
              PH_DY: begin
                phase_nxt  = PH_COUNT;
                column_nxt = column_r + POS_W'(dx_r);
                line_nxt   = line_r + POS_W'(data_byte);
                fin        = (column_nxt > POS_W'(w)) || (line_nxt >= POS_W'(h));
              end
              PH_LIT: begin
                sp_do = 1'b1;
                if (cfg.nibble_mode) begin
                  // The last byte of an odd pixel count carries one pixel.
                  sp_len = ({lit_index_r, 1'b1} < {1'b0, lit_pixels_r}) ? 8'd2 : 8'd1;
                  sp_ei  = data_byte >> 4;
                  sp_oi  = data_byte & NIB_MASK;
                end else begin
                  sp_len = 8'd1;
                  sp_ei  = data_byte;
                  sp_oi  = data_byte;
                end
                lit_index_nxt = lit_index_r + 8'd1;
                lit_left_nxt  = lit_left_r - 8'd1;
                if (lit_left_nxt == 8'd0) begin
                  phase_nxt = pad_r ? PH_PAD : PH_COUNT;
                end
              end
              PH_PAD: begin
                pad_nxt   = 1'b0;
                phase_nxt = PH_COUNT;
              end
              default: begin
                phase_nxt = PH_COUNT;
              end
            endcase
          end
        end
      endcase

      if (sp_do) begin
        if (sp_ok) begin
          column_nxt = sp_end[POS_W-1:0];
        end else begin
          fin = 1'b1;
        end
      end
      if (fin) begin
        ended_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    res = '0;
    if (fin) begin
      res.valid = 1'b1;
      res.kind  = fin_kind;
    end else if (sp_do) begin
      res.valid    = 1'b1;
      res.kind     = KIND_SPAN;
      res.x        = 16'(column_r);
      res.y        = 16'(y_full);
      res.len      = sp_len;
      res.odd_used = (sp_len >= 8'd2);
    end
  end

  assign pal_re    = accept & sp_do & ~fin;
  assign even_addr = sp_ei[PAL_AW-1:0];
  assign odd_addr  = sp_oi[PAL_AW-1:0];
  assign pal_waddr = palette_slot[PAL_AW-1:0];
  assign pal_wdata = palette_argb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_COUNT;
      run_count_r  <= 8'd0;
      column_r     <= '0;
      line_r       <= '0;
      lit_pixels_r <= 8'd0;
      lit_left_r   <= 8'd0;
      lit_index_r  <= 8'd0;
      pad_r        <= 1'b0;
      dx_r         <= 8'd0;
      ended_r      <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      run_count_r  <= run_count_nxt;
      column_r     <= column_nxt;
      line_r       <= line_nxt;
      lit_pixels_r <= lit_pixels_nxt;
      lit_left_r   <= lit_left_nxt;
      lit_index_r  <= lit_index_nxt;
      pad_r        <= pad_nxt;
      dx_r         <= dx_nxt;
      ended_r      <= ended_nxt;
    end
  end

endmodule

>>> design/bmprle_out.sv
`timescale 1ns / 1ps
module bmprle_out
  import bmprle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  res_t        res,
  input  logic [31:0] even_rdata,
  input  logic [31:0] odd_rdata,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [15:0] out_x,
  output logic [15:0] out_y,
  output logic [7:0]  out_len,
  output logic [31:0] out_even,
  output logic [31:0] out_odd
);

  // Stage one waits for the palette read; the output register follows it.
  logic        s1_v_r, s1_v_nxt;
  res_t        s1_res_r;
  logic        s1_move;
  logic        out_v_r, out_v_nxt;
  logic [1:0]  kind_r;
  logic [15:0] x_r, y_r;
  logic [7:0]  len_r;
  logic [31:0] even_r, odd_r;
  logic        is_span;

  assign s1_move  = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || s1_move;
  assign is_span  = (s1_res_r.kind == KIND_SPAN);

  always_comb begin
    if (accept) begin
      s1_v_nxt = res.valid;
    end else begin
      s1_v_nxt = s1_v_r && !s1_move;
    end
    if (s1_v_r && s1_move) begin
      out_v_nxt = 1'b1;
    end else begin
      out_v_nxt = out_v_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r <= res;
    end
    if (s1_v_r && s1_move) begin
      kind_r <= s1_res_r.kind;
      x_r    <= s1_res_r.x;
      y_r    <= s1_res_r.y;
      len_r  <= s1_res_r.len;
      even_r <= is_span ? even_rdata : 32'd0;
      odd_r  <= (is_span && s1_res_r.odd_used) ? odd_rdata : 32'd0;
    end
  end

  assign out_valid = out_v_r;
  assign out_kind  = kind_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_len   = len_r;
  assign out_even  = even_r;
  assign out_odd   = odd_r;

endmodule

>>> design/bmprle_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bmprle_chk
  import bmprle_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [15:0] span_x,
  input logic [15:0] span_y,
  input logic [7:0]  span_length,
  input logic [31:0] even_colour,
  input logic [31:0] odd_colour
);

  // A result beat that waits keeps its contents.
  `CHK_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(span_x) && $stable(span_y) && $stable(span_length) && $stable(even_colour) && $stable(odd_colour), "result beat changed while stalled")

  // Final results carry nothing but their kind.
  `CHK_ASSERT(a_final_zero, clk, rst_n, out_valid && kind != KIND_SPAN |-> span_x == 16'd0 && span_y == 16'd0 && span_length == 8'd0 && even_colour == 32'd0 && odd_colour == 32'd0, "final result with nonzero fields")

  `CHK_ASSERT(a_span_len, clk, rst_n, out_valid && kind == KIND_SPAN |-> span_length != 8'd0, "empty pixel span")

  `CHK_ASSERT(a_single_odd, clk, rst_n, out_valid && kind == KIND_SPAN && span_length == 8'd1 |-> odd_colour == 32'd0, "single pixel span with odd colour")

  `CHK_ASSERT_ALWAYS(a_reset_idle, clk, $past(!rst_n) |-> !out_valid, "result beat right after reset")

endmodule

bind bmp_rle_pixel_decoder bmprle_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .kind        (out_ch.kind),
  .span_x      (out_ch.span_x),
  .span_y      (out_ch.span_y),
  .span_length (out_ch.span_length),
  .even_colour (out_ch.even_colour),
  .odd_colour  (out_ch.odd_colour)
);

>>> dv/bmp_rle_pixel_decoder_tb.sv
`timescale 1ns / 1ps
module bmp_rle_pixel_decoder_tb;
  import bmprle_pkg::*;

  localparam int IDLE_PCT     = 17;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_TICKS = 8;
  localparam int RANDOM_BEATS = 760;
  localparam int PHASE_BEATS  = 130;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PLAN_ROWS    = 29;

  // Escape commands that follow a zero count byte.
  localparam logic [7:0] ESC_MARK  = 8'd0;
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  localparam logic [31:0] C0 = 32'hFFFF_FFFF;
  localparam logic [31:0] C1 = 32'h1234_5678;

  typedef enum logic [2:0] {AT_COUNT, AT_CMD, AT_DX, AT_DY, AT_LITERAL, AT_PAD} parse_at_t;
  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  len;
    logic [31:0] even;
    logic [31:0] odd;
  } span_beat_t;

  typedef struct packed {
    row_kind_t   what;
    logic [1:0]  code;
    logic [7:0]  slot;
    logic [31:0] value;
    logic [7:0]  data;
    logic        typed;
    span_beat_t  want;
  } plan_row_t;

  localparam span_beat_t NO_BEAT   = '0;
  localparam span_beat_t FAIL_BEAT = '{KIND_FAIL, 16'd0, 16'd0, 8'd0, 32'd0, 32'd0};
  localparam span_beat_t DONE_BEAT = '{KIND_DONE, 16'd0, 16'd0, 8'd0, 32'd0, 32'd0};

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  bmprle_in_if  byte_ch();
  bmprle_out_if span_ch();

  bmp_rle_pixel_decoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (byte_ch),
    .out_ch  (span_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder mirror: configuration, parser state and palette.
  logic [15:0] cfg_width = 16'd1;
  logic [15:0] cfg_height = 16'd1;
  logic cfg_nibble = 1'b0;
  logic [8:0] cfg_entries = 9'd256;
  parse_at_t parse_at = AT_COUNT;
  logic [7:0] run_len = '0, lit_pixels = '0, lit_left = '0, lit_idx = '0, dx_hold = '0;
  logic pad_due = 1'b0, image_done = 1'b0;
  logic [POS_W-1:0] col_pos = '0, row_pos = '0;
  logic [31:0] pal_mirror [PALETTE_DEPTH];

  span_beat_t spans_due[$];
  int unsigned beats_fed = 0;
  int spans_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int hold_left = 0;
  int next_hold_at = 120;
  bit steady = 1'b0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_BEAT, OP_PAL,      8'd0, C0,        8'd0,      1'b0, NO_BEAT},
    '{ROW_BEAT, OP_PAL,      8'd1, C1,        8'd0,      1'b0, NO_BEAT},
    '{ROW_BEAT, OP_BYTE,     8'd0, 32'd0,     8'd1,      1'b0, NO_BEAT},
    '{ROW_BEAT, OP_BYTE,     8'd0, 32'd0,     8'd0,      1'b1,
      '{KIND_SPAN, 16'd0, 16'd0, 8'd1, C0, 32'd0}},
    '{ROW_BEAT, OP_BYTE,     8'd0, 32'd0,     ESC_MARK,  1'b0, NO_BEAT},
    '{ROW_BEAT, OP_BYTE,     8'd0, 32'd0,     ESC_EOB,   1'b1, DONE_BEAT},
    '{ROW_BEAT, OP_EOS,      8'd0, 32'd0,     8'd0,      1'b0, NO_BEAT},
    '{ROW_BEAT, OP_START,    8'd0, 32'd0,     8'd0,      1'b0, NO_BEAT},
    '{ROW_BEAT, OP_EOS,      8'd0, 32'd0,     8'd0,      1'b1, FAIL_BEAT},
    '{ROW_BEAT, OP_START,    8'd0, 32'd0,     8'd0,      1'b0, NO_BEAT},
    '{ROW_REG,  REG_WIDTH,   8'd0, 32'hFFFF,  8'd0,      1'b0, NO_BEAT},
    '{ROW_REG,  REG_HEIGHT,  8'd0, 32'hFFFF,  8'd0,      1'b0, NO_BEAT},
    '{ROW_REG,  REG_NIBBLE,  8'd0, 32'd1,     8'd0,      1'b0, NO_BEAT},
    '{ROW_BEAT, OP_BYTE,     8'd0, 32'd0,     8'd255,    1'b0, NO_BEAT},
    '{ROW_BEAT, OP_BYTE,     8'd0, 32'd0,     8'h10,     1'b1,
      '{KIND_SPAN, 16'd0, 16'd65534, 8'd255, C1, C0}},
    '{ROW_BEAT, OP_BYTE,     8'd0, 32'd0,     ESC_MARK,  1'b0, NO_BEAT},
    '{ROW_BEAT, OP_BYTE,     8'd0, 32'd0,     ESC_DELTA, 1'b0, NO_BEAT},
    '{ROW_BEAT, OP_BYTE,     8'd0, 32'd0,     8'd255,    1'b0, NO_BEAT},
    '{ROW_BEAT, OP_BYTE,     8'd0, 32'd0,     8'd255,    1'b0, NO_BEAT},
    '{ROW_BEAT, OP_BYTE,     8'd0, 32'd0,     ESC_MARK,  1'b0, NO_BEAT},
    '{ROW_BEAT, OP_BYTE,     8'd0, 32'd0,     8'd3,      1'b0, NO_BEAT},
    '{ROW_BEAT, OP_BYTE,     8'd0, 32'd0,     8'h01,     1'b1,
      '{KIND_SPAN, 16'd510, 16'd65279, 8'd2, C0, C1}},
    '{ROW_BEAT, OP_BYTE,     8'd0, 32'd0,     8'h0F,     1'b1,
      '{KIND_SPAN, 16'd512, 16'd65279, 8'd1, C0, 32'd0}},
    '{ROW_REG,  REG_ENTRIES, 8'd0, 32'd2,     8'd0,      1'b0, NO_BEAT},
    '{ROW_BEAT, OP_BYTE,     8'd0, 32'd0,     8'd1,      1'b0, NO_BEAT},
    // The odd index is out of range but unused by a one-pixel span.
    '{ROW_BEAT, OP_BYTE,     8'd0, 32'd0,     8'h1F,     1'b1,
      '{KIND_SPAN, 16'd513, 16'd65279, 8'd1, C1, 32'd0}},
    '{ROW_BEAT, OP_BYTE,     8'd0, 32'd0,     8'd2,      1'b0, NO_BEAT},
    '{ROW_BEAT, OP_BYTE,     8'd0, 32'd0,     8'h12,     1'b1, FAIL_BEAT},
    '{ROW_BEAT, OP_START,    8'd0, 32'd0,     8'd0,      1'b0, NO_BEAT}
  };

  cfg_t presets [6] = '{
    '{16'd16,    16'd4,     1'b0, 9'd256},
    '{16'd8,     16'd2,     1'b1, 9'd16},
    '{16'hFFFF,  16'hFFFF,  1'b0, 9'd1},
    '{16'd1,     16'd1,     1'b1, 9'd256},
    '{16'd300,   16'd3,     1'b0, 9'd200},
    '{16'd40,    16'hFFFF,  1'b1, 9'd3}
  };

  function automatic int unsigned lesser(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic string show(span_beat_t s);
    return $sformatf("kind=%0d x=%0d y=%0d len=%0d even=%h odd=%h",
                     s.kind, s.x, s.y, s.len, s.even, s.odd);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic void clear_parse();
    parse_at = AT_COUNT;
    run_len = '0;
    col_pos = '0;
    row_pos = '0;
    lit_pixels = '0;
    lit_left = '0;
    lit_idx = '0;
    pad_due = 1'b0;
    dx_hold = '0;
    image_done = 1'b0;
  endfunction

  function automatic bit index_ok(int unsigned idx);
    return idx < cfg_entries && idx < PALETTE_DEPTH;
  endfunction

  function automatic span_beat_t close_image(logic [1:0] k);
    span_beat_t r;
    r = '0;
    r.kind = k;
    image_done = 1'b1;
    return r;
  endfunction

  function automatic span_beat_t paint_span(int unsigned len, int unsigned ei, int unsigned oi);
    span_beat_t r;
    int unsigned w, h;
    w = cfg_width;
    h = cfg_height;
    if (!(row_pos < h && col_pos + len <= w && index_ok(ei) && (len < 2 || index_ok(oi))))
      return close_image(KIND_FAIL);
    r.kind = KIND_SPAN;
    r.x = col_pos[15:0];
    r.y = 16'(h - 1 - row_pos);
    r.len = 8'(len);
    r.even = pal_mirror[ei];
    r.odd = (len >= 2) ? pal_mirror[oi] : 32'd0;
    col_pos = col_pos + POS_W'(len);
    return r;
  endfunction

  // Advances the mirror by one accepted beat; returns 1 when a result is due.
  function automatic bit decode_beat(input logic [1:0] op, input logic [7:0] slot,
                                     input logic [31:0] argb, input logic [7:0] b,
                                     output span_beat_t r);
    int unsigned w, h, pix;
    w = cfg_width;
    h = cfg_height;
    r = '0;
    if (op == OP_PAL) begin
      pal_mirror[slot] = argb;
      return 1'b0;
    end
    if (op == OP_START) begin
      clear_parse();
      return 1'b0;
    end
    if (image_done) return 1'b0;
    if (op == OP_EOS) begin
      r = close_image(KIND_FAIL);
      return 1'b1;
    end
    case (parse_at)
      AT_COUNT: begin
        run_len = b;
        parse_at = AT_CMD;
        return 1'b0;
      end
      AT_CMD: begin
        parse_at = AT_COUNT;
        if (run_len != 0) begin
          if (cfg_nibble) r = paint_span(run_len, b[7:4], b[3:0]);
          else r = paint_span(run_len, b, b);
          return 1'b1;
        end
        case (b)
          ESC_EOL: begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
            if (row_pos > h) begin
              r = close_image(KIND_FAIL);
              return 1'b1;
            end
            return 1'b0;
          end
          ESC_EOB: begin
            r = close_image((row_pos < h) ? KIND_DONE : KIND_FAIL);
            return 1'b1;
          end
          ESC_DELTA: begin
            parse_at = AT_DX;
            return 1'b0;
          end
          default: begin
            lit_pixels = b;
            lit_left = cfg_nibble ? 8'((int'(b) + 1) / 2) : b;
            lit_idx = '0;
            pad_due = lit_left[0];
            parse_at = AT_LITERAL;
            return 1'b0;
          end
        endcase
      end
      AT_DX: begin
        dx_hold = b;
        parse_at = AT_DY;
        return 1'b0;
      end
      AT_DY: begin
        parse_at = AT_COUNT;
        col_pos = col_pos + dx_hold;
        row_pos = row_pos + b;
        if (col_pos > w || row_pos >= h) begin
          r = close_image(KIND_FAIL);
          return 1'b1;
        end
        return 1'b0;
      end
      AT_LITERAL: begin
        if (cfg_nibble) begin
          pix = lit_idx;
          r = paint_span((pix * 2 + 1 < lit_pixels) ? 2 : 1, b[7:4], b[3:0]);
        end else begin
          r = paint_span(1, b, b);
        end
        lit_idx = lit_idx + 1'b1;
        lit_left = lit_left - 1'b1;
        if (lit_left == 0) parse_at = pad_due ? AT_PAD : AT_COUNT;
        return 1'b1;
      end
      AT_PAD: begin
        pad_due = 1'b0;
        parse_at = AT_COUNT;
        return 1'b0;
      end
      default: begin
        parse_at = AT_COUNT;
        return 1'b0;
      end
    endcase
  endfunction

  // Every task below starts and ends just after a falling edge.
  task automatic send_item(input logic [1:0] op, input logic [7:0] slot,
                           input logic [31:0] argb, input logic [7:0] data,
                           input bit typed = 1'b0, input span_beat_t want = '0);
    span_beat_t predicted;
    bit produces, ignored;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.operation <= op;
    byte_ch.palette_slot <= slot;
    byte_ch.palette_argb <= argb;
    byte_ch.data_byte <= data;
    do @(posedge clk); while (!byte_ch.ready);
    ignored = image_done && (op == OP_BYTE || op == OP_EOS);
    produces = decode_beat(op, slot, argb, data, predicted);
    if (typed) spans_due.insert(spans_due.size(), want);
    else if (produces) spans_due.insert(spans_due.size(), predicted);
    if (!ignored) beats_fed++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_BYTE, 8'($urandom), $urandom, b);
  endtask

  // Drops valid, waits for every expected result, then lets the pipeline drain.
  task automatic settle_block();
    byte_ch.valid <= 1'b0;
    while (spans_due.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] stored, got;
    case (idx)
      REG_WIDTH:   stored = {16'd0, value[15:0]};
      REG_HEIGHT:  stored = {16'd0, value[15:0]};
      REG_NIBBLE:  stored = {31'd0, value[0]};
      default:     stored = {23'd0, value[8:0]};
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_WIDTH:   cfg_width = value[15:0];
      REG_HEIGHT:  cfg_height = value[15:0];
      REG_NIBBLE:  cfg_nibble = value[0];
      default:     cfg_entries = value[8:0];
    endcase
    // Back-to-back read of the same register.
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== stored)
      note_mismatch($sformatf("register %0d reads %h, expected %h", idx, got, stored));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_colour();
    int unsigned lim;
    if ($urandom_range(19) == 0) return 8'($urandom);
    lim = cfg_nibble ? lesser(cfg_entries, 16) : cfg_entries;
    if (cfg_nibble) return {4'($urandom_range(lim - 1)), 4'($urandom_range(lim - 1))};
    return 8'($urandom_range(lim - 1));
  endfunction

  // Mostly counts that fit the rest of the row, sometimes anything.
  function automatic int unsigned pick_count(int unsigned lo, int unsigned room);
    int unsigned top;
    if (room >= lo && $urandom_range(9) != 0) begin
      top = lesser(room, ($urandom_range(7) == 0) ? 255 : 24);
      return $urandom_range(top, lo);
    end
    return $urandom_range(255, lo);
  endfunction

  // Well-formed command sequences with random content, plus some noise.
  task automatic random_image_stream(input int unsigned goal);
    int unsigned room, rows_left, n, nbytes, pick;
    send_item(OP_START, 8'($urandom), $urandom, 8'($urandom));
    while (beats_fed < goal) begin
      if (image_done) begin
        if ($urandom_range(3) == 0) send_byte(8'($urandom));
        if ($urandom_range(5) == 0) send_item(OP_EOS, 8'($urandom), $urandom, 8'($urandom));
        send_item(OP_START, 8'($urandom), $urandom, 8'($urandom));
      end else begin
        room = (col_pos > cfg_width) ? 0 : cfg_width - col_pos;
        rows_left = (row_pos > cfg_height) ? 0 : cfg_height - row_pos;
        pick = $urandom_range(99);
        if (pick < 4) begin
          send_item(OP_PAL, 8'($urandom), $urandom, 8'($urandom));
        end else if (pick < 8) begin
          send_item(2'($urandom_range(3)), 8'($urandom), $urandom, 8'($urandom));
        end else if (pick < 45) begin
          send_byte(8'(pick_count(1, room)));
          send_byte(pick_colour());
        end else if (pick < 65) begin
          n = pick_count(3, room);
          nbytes = cfg_nibble ? (n + 1) / 2 : n;
          send_byte(ESC_MARK);
          send_byte(8'(n));
          for (int i = 0; i < nbytes && !image_done; i++) send_byte(pick_colour());
          if (nbytes % 2 == 1 && !image_done) send_byte(8'($urandom));
        end else if (pick < 80) begin
          send_byte(ESC_MARK);
          send_byte(ESC_EOL);
        end else if (pick < 90) begin
          send_byte(ESC_MARK);
          send_byte(ESC_DELTA);
          if ($urandom_range(9) == 0) begin
            send_byte(8'($urandom));
            send_byte(8'($urandom));
          end else begin
            send_byte(8'($urandom_range(lesser(room, 255))));
            send_byte(8'((rows_left > 1) ? $urandom_range(lesser(rows_left - 1, 255)) : 0));
          end
        end else begin
          send_byte(ESC_MARK);
          send_byte(ESC_EOB);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    span_beat_t got, want;
    if (rst_n && span_ch.valid && span_ch.ready) begin
      got = '{span_ch.kind, span_ch.span_x, span_ch.span_y, span_ch.span_length,
              span_ch.even_colour, span_ch.odd_colour};
      spans_seen++;
      if (spans_due.size() == 0) begin
        note_mismatch($sformatf("beat with nothing expected: %s", show(got)));
      end else begin
        want = spans_due.pop_front();
        if (got !== want)
          note_mismatch($sformatf("expected %s, got %s", show(want), show(got)));
      end
    end
  end

  // Result side: random stalls, plus long hold-offs that back the block up.
  initial begin
    span_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        span_ch.ready <= 1'b0;
        hold_left--;
      end else if (spans_seen >= next_hold_at) begin
        span_ch.ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        next_hold_at += 400;
      end else begin
        span_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    cfg_t next_cfg;
    int unsigned goal;
    rst_n = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.operation = OP_PAL;
    byte_ch.palette_slot = '0;
    byte_ch.palette_argb = '0;
    byte_ch.data_byte = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Fill the whole palette so that no span can read an unwritten entry.
    for (int s = 0; s < PALETTE_DEPTH; s++)
      send_item(OP_PAL, 8'(s), $urandom, 8'($urandom));

    foreach (plan[i]) begin
      if (plan[i].what == ROW_REG) begin
        settle_block();
        write_reg(plan[i].code, plan[i].value);
      end else begin
        send_item(plan[i].code, plan[i].slot, plan[i].value, plan[i].data,
                  plan[i].typed, plan[i].want);
      end
    end

    goal = beats_fed + RANDOM_BEATS;
    for (int p = 0; beats_fed < goal; p++) begin
      if (p < 6) begin
        next_cfg = presets[p];
      end else begin
        next_cfg.image_width = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom_range(64, 1));
        next_cfg.image_height = 16'($urandom_range(8, 1));
        next_cfg.nibble_mode = 1'($urandom_range(1));
        next_cfg.palette_entries = 9'($urandom_range(256, 1));
      end
      steady = 1'b0;
      settle_block();
      write_reg(REG_WIDTH, {16'd0, next_cfg.image_width});
      write_reg(REG_HEIGHT, {16'd0, next_cfg.image_height});
      write_reg(REG_NIBBLE, {31'd0, next_cfg.nibble_mode});
      write_reg(REG_ENTRIES, {23'd0, next_cfg.palette_entries});
      // One whole phase runs without random idle cycles on either side; the long hold-offs still apply.
      steady = (p == 2);
      random_image_stream(beats_fed + PHASE_BEATS);
    end
    steady = 1'b0;
    settle_block();

    if (mismatches == 0 && spans_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> bmp_rle_pixel_decoder.f
+incdir+design
design/bmprle_pkg.sv
design/bmprle_ifs.sv
design/bmprle_ram.sv
design/bmprle_cfg.sv
design/bmprle_parser.sv
design/bmprle_out.sv
design/bmp_rle_pixel_decoder.sv
design/bmprle_chk.sv
dv/bmp_rle_pixel_decoder_tb.sv
